// ===== rtl/core/smeu_pkg.sv =====
// shared types and codes of the stack machine execute unit
`default_nettype none
package smeu_pkg;

  localparam int unsigned DataDepthDef   = 64;
  localparam int unsigned ReturnDepthDef = 32;
  localparam int unsigned CellWidthDef   = 32;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [4:0] {
    OP_LIT       = 5'd0,
    OP_ADD       = 5'd1,
    OP_SUB       = 5'd2,
    OP_MUL       = 5'd3,
    OP_DIV       = 5'd4,
    OP_DUP       = 5'd5,
    OP_DROP      = 5'd6,
    OP_SWAP      = 5'd7,
    OP_OVER      = 5'd8,
    OP_ROT       = 5'd9,
    OP_EQ        = 5'd10,
    OP_LT        = 5'd11,
    OP_GT        = 5'd12,
    OP_ZERO_EQ   = 5'd13,
    OP_DEPTH     = 5'd14,
    OP_TO_R      = 5'd15,
    OP_FROM_R    = 5'd16,
    OP_R_FETCH   = 5'd17,
    OP_POP_OUT   = 5'd18,
    OP_BRANCH_Z  = 5'd19,
    OP_DO        = 5'd20,
    OP_LOOP      = 5'd21,
    OP_I         = 5'd22,
    OP_J         = 5'd23,
    OP_STEP_LOOP = 5'd24
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUNDER  = 3'd1,
    ST_DOVER   = 3'd2,
    ST_RUNDER  = 3'd3,
    ST_ROVER   = 3'd4,
    ST_DIVZERO = 3'd5,
    ST_BADINC  = 3'd6,
    ST_BADOP   = 3'd7
  } status_e;

  // how the whole row of cells moves
  typedef enum logic [2:0] {
    SH_HOLD  = 3'd0,
    SH_PUSH1 = 3'd1,
    SH_PUSH2 = 3'd2,
    SH_POP1  = 3'd3,
    SH_POP2  = 3'd4
  } shift_e;

  // per-cell control from the sequencer
  typedef struct packed {
    shift_e sh;
    logic   ld;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/smeu_cell.sv =====
// one stack cell: holds an entry, takes it from a neighbor or a load
`default_nettype none
module smeu_cell import smeu_pkg::*; #(
  parameter int unsigned CellWidth = CellWidthDef
) (
  input  wire logic                 clk_i,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [CellWidth-1:0] ld_val_i,
  input  wire logic [CellWidth-1:0] up1_i,
  input  wire logic [CellWidth-1:0] up2_i,
  input  wire logic [CellWidth-1:0] dn1_i,
  input  wire logic [CellWidth-1:0] dn2_i,
  output logic      [CellWidth-1:0] val_o
);

  logic [CellWidth-1:0] val_d, val_q;

  always_comb begin
    if (ctrl_i.ld) begin
      val_d = ld_val_i;
    end else begin
      case (ctrl_i.sh)
        SH_PUSH1: val_d = up1_i;
        SH_PUSH2: val_d = up2_i;
        SH_POP1:  val_d = dn1_i;
        SH_POP2:  val_d = dn2_i;
        default:  val_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

// ===== rtl/core/smeu_div.sv =====
// iterative signed divider, one quotient bit per cycle
`default_nettype none
module smeu_div import smeu_pkg::*; #(
  parameter int unsigned CellWidth = CellWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [CellWidth-1:0] num_i,
  input  wire logic [CellWidth-1:0] den_i,
  output logic                      done_o,
  output logic      [CellWidth-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(CellWidth + 1);

  logic                 busy_d, busy_q;
  logic [CntW-1:0]      cnt_d, cnt_q;
  logic [CellWidth-1:0] rem_d, rem_q;
  logic [CellWidth-1:0] q_d, q_q;
  logic [CellWidth-1:0] den_d, den_q;
  logic                 neg_d, neg_q;
  logic [CellWidth:0]   trial;
  logic [CellWidth:0]   diff;

  assign done_o = busy_q && (cnt_q == CntW'(CellWidth));
  assign quo_o  = neg_q ? (~q_q + 1'b1) : q_q;
  assign trial  = {rem_q, q_q[CellWidth-1]};
  assign diff   = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    q_d    = q_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      q_d    = num_i[CellWidth-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[CellWidth-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[CellWidth-1] ^ den_i[CellWidth-1];
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[CellWidth-1:0];
        q_d   = {q_q[CellWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[CellWidth-1:0];
        q_d   = {q_q[CellWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_execute_unit.sv =====
// top level of the stack machine execute unit
`default_nettype none
// Executes one stack-machine operation per input item and returns one result
// item with status, jump flag, popped value and both stack depths. Both stacks
// are rows of shift cells with the top of stack in cell zero; every operation
// moves the whole row by at most two places and reloads the top cells, so all
// operations but divide show their result in the cycle after the accept.
// Divide runs through an iterative unit at one quotient bit per cycle, and no
// new item is accepted meanwhile. A new item is taken while the previous
// result still waits, as long as the result register frees in the same cycle.
module stack_machine_execute_unit import smeu_pkg::*; #(
  parameter int unsigned DATA_DEPTH   = DataDepthDef,
  parameter int unsigned RETURN_DEPTH = ReturnDepthDef,
  parameter int unsigned CELL_WIDTH   = CellWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // mode [4:0], literal [36:5], zeros above
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status [2:0], taken [3], out_valid [4], out_value [36:5],
  // data_depth [43:37], return_depth [49:44], zeros above
  output logic      [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned W   = CELL_WIDTH;
  localparam int unsigned DPW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned RPW = $clog2(RETURN_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic [DPW-1:0] dp_d, dp_q;
  logic [RPW-1:0] rp_d, rp_q;
  logic           ovld_d, ovld_q;
  logic [OutDataW-1:0] odata_d, odata_q;

  // stack rows, cell zero is top of stack
  logic [W-1:0] dcell [DATA_DEPTH];
  logic [W-1:0] rcell [RETURN_DEPTH];

  logic [4:0]  in_mode;
  logic [31:0] in_lit;
  logic        accept, apply, div_start, div_done;
  logic [W-1:0] quo;
  logic [W-1:0] t0, t1, t2, r0, r1, r2;

  // decoded operation
  status_e      st;
  logic         taken, ov;
  logic [W-1:0] oval;
  shift_e       dsh, rsh;
  logic [2:0]   dld;
  logic [W-1:0] dv [3];
  logic [1:0]   rld;
  logic [W-1:0] rv [2];
  logic         is_div;

  assign in_mode = s_axis_tdata[4:0];
  assign in_lit  = s_axis_tdata[36:5];
  assign t0 = dcell[0];
  assign t1 = dcell[1];
  assign t2 = dcell[2];
  assign r0 = rcell[0];
  assign r1 = rcell[1];
  assign r2 = rcell[2];

  // result register frees when taken, so a new item may enter that cycle
  assign s_axis_tready = (state_q == S_IDLE) && (!ovld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // signed compare on cells: flip sign bits, compare unsigned
  function automatic logic cell_lt(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] fa, fb;
    fa = a ^ {1'b1, {(W-1){1'b0}}};
    fb = b ^ {1'b1, {(W-1){1'b0}}};
    return fa < fb;
  endfunction

  always_comb begin
    logic [W-1:0] a, c;
    logic         room;
    logic [4:0]   mode;
    mode   = (state_q == S_DIV) ? OP_DIV : in_mode;
    room   = dp_q < DPW'(DATA_DEPTH);
    st     = ST_OK;
    taken  = 1'b0;
    ov     = 1'b0;
    oval   = '0;
    dsh    = SH_HOLD;
    rsh    = SH_HOLD;
    dld    = '0;
    rld    = '0;
    dv[0]  = '0;
    dv[1]  = '0;
    dv[2]  = '0;
    rv[0]  = '0;
    rv[1]  = '0;
    is_div = 1'b0;
    a      = '0;
    c      = '0;
    case (mode)
      OP_LIT: begin
        if (!room) st = ST_DOVER;
        else begin dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = W'($signed(in_lit)); end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
        if (dp_q < DPW'(2)) st = ST_DUNDER;
        else if (mode == OP_DIV && t0 == '0) st = ST_DIVZERO;
        else begin
          case (mode)
            OP_ADD:  c = t1 + t0;
            OP_SUB:  c = t1 - t0;
            OP_MUL:  c = W'(t1 * t0);
            OP_DIV:  c = quo;
            OP_EQ:   c = (t1 == t0) ? '1 : '0;
            OP_LT:   c = cell_lt(t1, t0) ? '1 : '0;
            default: c = cell_lt(t0, t1) ? '1 : '0;
          endcase
          is_div = (mode == OP_DIV);
          dsh = SH_POP1; dld[0] = 1'b1; dv[0] = c;
        end
      end
      OP_DUP: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else if (!room) st = ST_DOVER;
        else begin dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = t0; end
      end
      OP_DROP: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else dsh = SH_POP1;
      end
      OP_SWAP: begin
        if (dp_q < DPW'(2)) st = ST_DUNDER;
        else begin dld[1:0] = 2'b11; dv[0] = t1; dv[1] = t0; end
      end
      OP_OVER: begin
        if (dp_q < DPW'(2)) st = ST_DUNDER;
        else if (!room) st = ST_DOVER;
        else begin dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = t1; end
      end
      OP_ROT: begin
        if (dp_q < DPW'(3)) st = ST_DUNDER;
        else begin dld = 3'b111; dv[0] = t2; dv[1] = t0; dv[2] = t1; end
      end
      OP_ZERO_EQ: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else begin dld[0] = 1'b1; dv[0] = (t0 == '0) ? '1 : '0; end
      end
      OP_DEPTH: begin
        if (!room) st = ST_DOVER;
        else begin dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = W'(dp_q); end
      end
      OP_TO_R: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else if (rp_q >= RPW'(RETURN_DEPTH)) st = ST_ROVER;
        else begin dsh = SH_POP1; rsh = SH_PUSH1; rld[0] = 1'b1; rv[0] = t0; end
      end
      OP_FROM_R, OP_R_FETCH: begin
        if (rp_q == '0) st = ST_RUNDER;
        else if (!room) st = ST_DOVER;
        else begin
          dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = r0;
          if (mode == OP_FROM_R) rsh = SH_POP1;
        end
      end
      OP_POP_OUT: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else begin dsh = SH_POP1; ov = 1'b1; oval = t0; end
      end
      OP_BRANCH_Z: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else begin dsh = SH_POP1; taken = (t0 == '0); end
      end
      OP_DO: begin
        if (dp_q < DPW'(2)) st = ST_DUNDER;
        else begin
          // start and limit stay popped even when the return stack is full
          dsh = SH_POP2;
          if (t0 == t1) taken = 1'b1;
          else if (rp_q > RPW'(RETURN_DEPTH - 2)) st = ST_ROVER;
          else begin rsh = SH_PUSH2; rld = 2'b11; rv[0] = t0; rv[1] = t1; end
        end
      end
      OP_LOOP: begin
        if (rp_q < RPW'(2)) st = ST_RUNDER;
        else begin
          a = r0 + 1'b1;
          if (a == r1) rsh = SH_POP2;
          else begin rld[0] = 1'b1; rv[0] = a; taken = 1'b1; end
        end
      end
      OP_I, OP_J: begin
        if (rp_q < ((mode == OP_I) ? RPW'(2) : RPW'(4))) st = ST_RUNDER;
        else if (!room) st = ST_DOVER;
        else begin
          dsh = SH_PUSH1; dld[0] = 1'b1; dv[0] = (mode == OP_I) ? r0 : r2;
        end
      end
      OP_STEP_LOOP: begin
        if (dp_q < DPW'(1)) st = ST_DUNDER;
        else if (rp_q < RPW'(2)) st = ST_RUNDER;
        else begin
          // increment stays popped when it is rejected
          dsh = SH_POP1;
          if (t0 == '0 || t0[W-1]) st = ST_BADINC;
          else begin
            a = r0 + t0;
            if (!cell_lt(a, r1)) rsh = SH_POP2;
            else begin rld[0] = 1'b1; rv[0] = a; taken = 1'b1; end
          end
        end
      end
      default: st = ST_BADOP;
    endcase
  end

  // a valid divide first runs the divider, then commits like any other op
  assign div_start = accept && is_div;
  assign apply     = (accept && !is_div) || div_done;

  smeu_div #(.CellWidth(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t1),
    .den_i   (t0),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // data stack row
  for (genvar k = 0; k < DATA_DEPTH; k++) begin : g_dcell
    cell_ctrl_t   ctl;
    logic [W-1:0] ldv, u1, u2, d1, d2;
    assign u1 = (k >= 1) ? dcell[(k >= 1) ? k - 1 : 0] : '0;
    assign u2 = (k >= 2) ? dcell[(k >= 2) ? k - 2 : 0] : '0;
    assign d1 = (k + 1 < DATA_DEPTH) ? dcell[(k + 1 < DATA_DEPTH) ? k + 1 : k] : '0;
    assign d2 = (k + 2 < DATA_DEPTH) ? dcell[(k + 2 < DATA_DEPTH) ? k + 2 : k] : '0;
    assign ctl.sh = apply ? dsh : SH_HOLD;
    assign ctl.ld = (k < 3) ? (apply && dld[(k < 3) ? k : 0]) : 1'b0;
    assign ldv    = (k < 3) ? dv[(k < 3) ? k : 0] : '0;
    smeu_cell #(.CellWidth(W)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctl),
      .ld_val_i (ldv),
      .up1_i    (u1),
      .up2_i    (u2),
      .dn1_i    (d1),
      .dn2_i    (d2),
      .val_o    (dcell[k])
    );
  end

  // return stack row
  for (genvar k = 0; k < RETURN_DEPTH; k++) begin : g_rcell
    cell_ctrl_t   ctl;
    logic [W-1:0] ldv, u1, u2, d1, d2;
    assign u1 = (k >= 1) ? rcell[(k >= 1) ? k - 1 : 0] : '0;
    assign u2 = (k >= 2) ? rcell[(k >= 2) ? k - 2 : 0] : '0;
    assign d1 = (k + 1 < RETURN_DEPTH) ? rcell[(k + 1 < RETURN_DEPTH) ? k + 1 : k] : '0;
    assign d2 = (k + 2 < RETURN_DEPTH) ? rcell[(k + 2 < RETURN_DEPTH) ? k + 2 : k] : '0;
    assign ctl.sh = apply ? rsh : SH_HOLD;
    assign ctl.ld = (k < 2) ? (apply && rld[(k < 2) ? k : 0]) : 1'b0;
    assign ldv    = (k < 2) ? rv[(k < 2) ? k : 0] : '0;
    smeu_cell #(.CellWidth(W)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctl),
      .ld_val_i (ldv),
      .up1_i    (u1),
      .up2_i    (u2),
      .dn1_i    (d1),
      .dn2_i    (d2),
      .val_o    (rcell[k])
    );
  end

  // pointers, state and result register
  always_comb begin
    dp_d    = dp_q;
    rp_d    = rp_q;
    state_d = state_q;
    ovld_d  = ovld_q && !m_axis_tready;
    odata_d = odata_q;
    if (div_start) state_d = S_DIV;
    if (div_done)  state_d = S_IDLE;
    if (apply) begin
      case (dsh)
        SH_PUSH1: dp_d = dp_q + 1'b1;
        SH_POP1:  dp_d = dp_q - 1'b1;
        SH_POP2:  dp_d = dp_q - DPW'(2);
        default:  dp_d = dp_q;
      endcase
      case (rsh)
        SH_PUSH1: rp_d = rp_q + 1'b1;
        SH_PUSH2: rp_d = rp_q + RPW'(2);
        SH_POP1:  rp_d = rp_q - 1'b1;
        SH_POP2:  rp_d = rp_q - RPW'(2);
        default:  rp_d = rp_q;
      endcase
      ovld_d  = 1'b1;
      odata_d = {6'b0, 6'(rp_d), 7'(dp_d), 32'(oval), ov, taken, st};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dp_q    <= '0;
      rp_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dp_q    <= dp_d;
      rp_q    <= rp_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  a_dp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_q <= DPW'(DATA_DEPTH))
    else $error("data pointer beyond stack depth");

  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= RPW'(RETURN_DEPTH))
    else $error("return pointer beyond stack depth");

  a_div_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !s_axis_tready)
    else $error("item accepted during divide");

  a_div_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> m_axis_tvalid)
    else $error("divide finished without a result");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench of the stack machine execute unit
`default_nettype none
module tb import smeu_pkg::*; ();

  localparam int unsigned DDEPTH = 64;
  localparam int unsigned RDEPTH = 32;

  typedef struct packed {
    logic [5:0]  rdepth;
    logic [6:0]  ddepth;
    logic [31:0] value;
    logic        ovalid;
    logic        taken;
    status_e     status;
  } exec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  always #6 clk_i = ~clk_i;

  stack_machine_execute_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // predictor state
  logic [31:0] dstk [DDEPTH];
  logic [31:0] rstk [RDEPTH];
  int unsigned dsp = 0;
  int unsigned rsp = 0;

  exec_result_t expected_q[$];
  int unsigned  mismatches = 0;
  int unsigned  hold_off = 0;
  bit           gap_enable = 1'b1;

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic exec_result_t execute_op(logic [4:0] op, logic [31:0] lit);
    exec_result_t r;
    logic [31:0] a, b, c;
    int unsigned d, rp;
    bit room;
    d = dsp; rp = rsp; room = d < DDEPTH;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_LIT: if (!room) r.status = ST_DOVER; else begin dstk[dsp] = lit; dsp++; end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
        if (d < 2) r.status = ST_DUNDER;
        else begin
          a = dstk[d-2]; b = dstk[d-1];
          if (op == OP_DIV && b == 0) r.status = ST_DIVZERO;
          else begin
            case (op)
              OP_ADD: c = a + b;
              OP_SUB: c = a - b;
              OP_MUL: c = a * b;
              OP_DIV: c = sdiv(a, b);
              OP_EQ:  c = (a == b) ? '1 : '0;
              OP_LT:  c = ($signed(a) < $signed(b)) ? '1 : '0;
              default: c = ($signed(b) < $signed(a)) ? '1 : '0;
            endcase
            dstk[d-2] = c; dsp = d - 1;
          end
        end
      end
      OP_DUP: if (d < 1) r.status = ST_DUNDER;
        else if (!room) r.status = ST_DOVER;
        else begin dstk[d] = dstk[d-1]; dsp++; end
      OP_DROP: if (d < 1) r.status = ST_DUNDER; else dsp--;
      OP_SWAP: if (d < 2) r.status = ST_DUNDER;
        else begin a = dstk[d-1]; dstk[d-1] = dstk[d-2]; dstk[d-2] = a; end
      OP_OVER: if (d < 2) r.status = ST_DUNDER;
        else if (!room) r.status = ST_DOVER;
        else begin dstk[d] = dstk[d-2]; dsp++; end
      OP_ROT: if (d < 3) r.status = ST_DUNDER;
        else begin
          a = dstk[d-3]; dstk[d-3] = dstk[d-2]; dstk[d-2] = dstk[d-1]; dstk[d-1] = a;
        end
      OP_ZERO_EQ: if (d < 1) r.status = ST_DUNDER;
        else dstk[d-1] = (dstk[d-1] == 0) ? '1 : '0;
      OP_DEPTH: if (!room) r.status = ST_DOVER; else begin dstk[d] = d; dsp++; end
      OP_TO_R: if (d < 1) r.status = ST_DUNDER;
        else if (rp >= RDEPTH) r.status = ST_ROVER;
        else begin dsp--; rstk[rp] = dstk[dsp]; rsp++; end
      OP_FROM_R, OP_R_FETCH: if (rp == 0) r.status = ST_RUNDER;
        else if (!room) r.status = ST_DOVER;
        else begin
          dstk[d] = rstk[rp-1]; dsp++;
          if (op == OP_FROM_R) rsp--;
        end
      OP_POP_OUT: if (d < 1) r.status = ST_DUNDER;
        else begin dsp--; r.value = dstk[dsp]; r.ovalid = 1'b1; end
      OP_BRANCH_Z: if (d < 1) r.status = ST_DUNDER;
        else begin dsp--; r.taken = (dstk[dsp] == 0); end
      OP_DO: if (d < 2) r.status = ST_DUNDER;
        else begin
          a = dstk[d-1]; b = dstk[d-2]; dsp = d - 2;
          if (a == b) r.taken = 1'b1;
          else if (RDEPTH - rp < 2) r.status = ST_ROVER;
          else begin rstk[rp] = b; rstk[rp+1] = a; rsp = rp + 2; end
        end
      OP_LOOP: if (rp < 2) r.status = ST_RUNDER;
        else begin
          a = rstk[rp-1] + 1;
          if (a == rstk[rp-2]) rsp = rp - 2;
          else begin rstk[rp-1] = a; r.taken = 1'b1; end
        end
      OP_I, OP_J: if (rp < ((op == OP_I) ? 2 : 4)) r.status = ST_RUNDER;
        else if (!room) r.status = ST_DOVER;
        else begin dstk[d] = rstk[rp - ((op == OP_I) ? 1 : 3)]; dsp++; end
      OP_STEP_LOOP: if (d < 1) r.status = ST_DUNDER;
        else if (rp < 2) r.status = ST_RUNDER;
        else begin
          dsp--; c = dstk[dsp];
          if (c == 0 || c[31]) r.status = ST_BADINC;
          else begin
            a = rstk[rp-1] + c;
            if (!($signed(a) < $signed(rstk[rp-2]))) rsp = rp - 2;
            else begin rstk[rp-1] = a; r.taken = 1'b1; end
          end
        end
      default: r.status = ST_BADOP;
    endcase
    r.ddepth = dsp[6:0];
    r.rdepth = rsp[5:0];
    return r;
  endfunction

  // sends one item; valid drops only during a random gap between bursts
  task automatic send_op(logic [4:0] op, logic [31:0] lit = $urandom);
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, lit, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(execute_op(op, lit));
  endtask

  // receiver stall pattern and the long hold-off
  always @(posedge clk_i) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    exec_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[49:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d tk=%0b ov=%0b val=%h dd=%0d rd=%0d,",
                      " got st=%0d tk=%0b ov=%0b val=%h dd=%0d rd=%0d"},
                     want.status, want.taken, want.ovalid, want.value,
                     want.ddepth, want.rdepth,
                     got.status, got.taken, got.ovalid, got.value,
                     got.ddepth, got.rdepth);
        end
      end
    end
  end

  task automatic test_directed();
    send_op(OP_DROP);
    send_op(OP_FROM_R);
    send_op(OP_LOOP);
    send_op(OP_LIT, 32'h8000_0000);
    send_op(OP_LIT, 32'hFFFF_FFFF);
    send_op(OP_DIV);
    send_op(OP_LIT, 32'h7FFF_FFFF);
    send_op(OP_LIT, 32'h0);
    send_op(OP_DIV);
    send_op(OP_ADD);
    send_op(OP_LIT, 5); send_op(OP_LIT, 5); send_op(OP_DO);
    send_op(OP_LIT, 3); send_op(OP_LIT, 0); send_op(OP_DO);
    send_op(OP_I); send_op(OP_POP_OUT); send_op(OP_LOOP);
    send_op(OP_LIT, 0); send_op(OP_STEP_LOOP);
    send_op(5'd25); send_op(5'd31);
    send_op(OP_BRANCH_Z);
  endtask

  // counted loops with random bodies
  task automatic test_loops(int n);
    logic [4:0] op;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: send_op(OP_LIT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8));
        2: begin send_op(OP_LIT, $urandom_range(0, 6)); send_op(OP_LIT, $urandom_range(0, 3));
             send_op(OP_DO); end
        3: send_op(OP_LOOP);
        4: begin send_op(OP_LIT, $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom);
             send_op(OP_STEP_LOOP); end
        default: begin
          op = 5'($urandom_range(0, 31));
          send_op(op);
        end
      endcase
    end
  endtask

  // fill both stacks to the top and beyond
  task automatic test_full_stacks();
    repeat (DDEPTH + 2) send_op(OP_DEPTH);
    send_op(OP_DUP); send_op(OP_OVER); send_op(OP_I);
    repeat (RDEPTH + 2) send_op(OP_TO_R);
    send_op(OP_DO);
    repeat (RDEPTH + 2) send_op(OP_DROP);
    send_op(OP_R_FETCH); send_op(OP_J); send_op(OP_FROM_R);
    repeat (DDEPTH + 4) send_op(OP_POP_OUT);
    repeat (RDEPTH + 2) send_op(OP_FROM_R);
    repeat (RDEPTH) send_op(OP_DROP);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    gap_enable = 1'b0;
    hold_off = 60;
    repeat (20) send_op(5'($urandom_range(0, 24)));
    gap_enable = 1'b1;
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_stacks();
    test_backpressure();
    test_loops(500);
    gap_enable = 1'b0;
    test_loops(150);
    gap_enable = 1'b1;
    test_loops(220);
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
